>>> rtl/mlfq_pkg.sv
package mlfq_pkg;

    // Sizing of the queue structure
    localparam int NUM_LEVELS = 8;
    localparam int MAX_JOBS   = 64;
    localparam int LVL_W      = 3;
    localparam int SLOT_W     = $clog2(MAX_JOBS);
    localparam int CNT_W      = SLOT_W + 1;
    localparam int FIFO_DEPTH = NUM_LEVELS * MAX_JOBS;

    // Port widths
    localparam int S_TDATA_W  = 112;
    localparam int M_TDATA_W  = 160;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_QUANTUM   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST_INTERVAL = 8'd1;

    // Result kinds
    localparam logic [1:0] OUT_IDLE    = 2'd0;
    localparam logic [1:0] OUT_ROTATE  = 2'd1;
    localparam logic [1:0] OUT_BLOCKED = 2'd2;
    localparam logic [1:0] OUT_DONE    = 2'd3;

    // Datapath operations issued by the controller
    localparam logic [4:0] OP_NONE      = 5'd0;
    localparam logic [4:0] OP_ACCEPT    = 5'd1;
    localparam logic [4:0] OP_E_READ    = 5'd2;
    localparam logic [4:0] OP_E_WRITE   = 5'd3;
    localparam logic [4:0] OP_BOOST     = 5'd4;
    localparam logic [4:0] OP_B_NEXTLVL = 5'd5;
    localparam logic [4:0] OP_B_FREAD   = 5'd6;
    localparam logic [4:0] OP_B_JREAD   = 5'd7;
    localparam logic [4:0] OP_B_JWRITE  = 5'd8;
    localparam logic [4:0] OP_S_START   = 5'd9;
    localparam logic [4:0] OP_S_NEXTLVL = 5'd10;
    localparam logic [4:0] OP_S_FREAD   = 5'd11;
    localparam logic [4:0] OP_S_JREAD   = 5'd12;
    localparam logic [4:0] OP_S_EVAL    = 5'd13;
    localparam logic [4:0] OP_POW       = 5'd14;
    localparam logic [4:0] OP_DEMOTE    = 5'd15;
    localparam logic [4:0] OP_RUN       = 5'd16;
    localparam logic [4:0] OP_UPDATE    = 5'd17;
    localparam logic [4:0] OP_IDLE_OUT  = 5'd18;

    // One job record as kept in the job memory
    typedef struct packed {
        logic [7:0]       id;
        logic [LVL_W-1:0] lvl;
        logic [31:0]      start;
        logic             started;
        logic [15:0]      work;
        logic [15:0]      quantum;
        logic             has_io;
        logic [15:0]      io_after;
        logic [15:0]      io_length;
    } job_rec_t;

    // Input transaction payload, lowest field in the lowest bits
    typedef struct packed {
        logic [2:0]  pad;
        logic [31:0] blocked_at;
        logic [15:0] io_length;
        logic [15:0] io_after;
        logic        has_io;
        logic [15:0] work_left;
        logic [15:0] quantum_left;
        logic [2:0]  level;
        logic        is_new;
        logic [7:0]  job_id;
    } in_item_t;

    // Result transaction payload, lowest field in the lowest bits
    typedef struct packed {
        logic [4:0]  pad;
        logic [15:0] out_work;
        logic [15:0] out_quantum;
        logic [2:0]  out_level;
        logic [31:0] ready_at;
        logic [31:0] first_run;
        logic [31:0] now_time;
        logic [15:0] ran_ticks;
        logic [7:0]  job_id_res;
    } out_item_t;

    typedef struct packed {
        logic [4:0] op;
    } mlfq_cmd_t;

    typedef struct packed {
        logic in_mode;
        logic in_queued;
        logic boost_due;
        logic k_lt_count;
        logic count_nz;
        logic lv_last;
        logic q_zero;
        logic pow_done;
        logic out_free;
    } mlfq_status_t;

endpackage

>>> rtl/mlfq_ram.sv
module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/mlfq_ctrl.sv
module mlfq_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  mlfq_pkg::mlfq_status_t status,
    output mlfq_pkg::mlfq_cmd_t    cmd
);
    import mlfq_pkg::*;

    localparam logic [4:0] ST_IDLE     = 5'd0;
    localparam logic [4:0] ST_E_RD     = 5'd1;
    localparam logic [4:0] ST_E_WR     = 5'd2;
    localparam logic [4:0] ST_D_CHK    = 5'd3;
    localparam logic [4:0] ST_B_LVL    = 5'd4;
    localparam logic [4:0] ST_B_JRD    = 5'd5;
    localparam logic [4:0] ST_B_JWR    = 5'd6;
    localparam logic [4:0] ST_S_LVL    = 5'd7;
    localparam logic [4:0] ST_S_JRD    = 5'd8;
    localparam logic [4:0] ST_S_EVAL   = 5'd9;
    localparam logic [4:0] ST_POW      = 5'd10;
    localparam logic [4:0] ST_RUN      = 5'd11;
    localparam logic [4:0] ST_UPD      = 5'd12;
    localparam logic [4:0] ST_IDLE_OUT = 5'd13;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    // Next state and the operation for the datapath in this cycle.
    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op = OP_ACCEPT;
                    if (status.in_mode) begin
                        state_next = ST_D_CHK;
                    end else if (!status.in_queued) begin
                        state_next = ST_E_RD;
                    end
                end
            end
            ST_E_RD: begin
                cmd.op     = OP_E_READ;
                state_next = ST_E_WR;
            end
            ST_E_WR: begin
                cmd.op     = OP_E_WRITE;
                state_next = ST_IDLE;
            end
            ST_D_CHK: begin
                if (status.boost_due) begin
                    cmd.op     = OP_BOOST;
                    state_next = ST_B_LVL;
                end else begin
                    cmd.op     = OP_S_START;
                    state_next = ST_S_LVL;
                end
            end
            ST_B_LVL: begin
                if (status.k_lt_count) begin
                    cmd.op     = OP_B_FREAD;
                    state_next = ST_B_JRD;
                end else begin
                    cmd.op = OP_B_NEXTLVL;
                    if (status.lv_last) begin
                        state_next = ST_S_LVL;
                    end
                end
            end
            ST_B_JRD: begin
                cmd.op     = OP_B_JREAD;
                state_next = ST_B_JWR;
            end
            ST_B_JWR: begin
                cmd.op     = OP_B_JWRITE;
                state_next = ST_B_LVL;
            end
            ST_S_LVL: begin
                if (status.count_nz) begin
                    cmd.op     = OP_S_FREAD;
                    state_next = ST_S_JRD;
                end else if (status.lv_last) begin
                    state_next = ST_IDLE_OUT;
                end else begin
                    cmd.op = OP_S_NEXTLVL;
                end
            end
            ST_S_JRD: begin
                cmd.op     = OP_S_JREAD;
                state_next = ST_S_EVAL;
            end
            ST_S_EVAL: begin
                cmd.op     = OP_S_EVAL;
                state_next = status.q_zero ? ST_POW : ST_RUN;
            end
            ST_POW: begin
                if (status.pow_done) begin
                    cmd.op     = OP_DEMOTE;
                    state_next = ST_S_LVL;
                end else begin
                    cmd.op = OP_POW;
                end
            end
            ST_RUN: begin
                cmd.op     = OP_RUN;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (status.out_free) begin
                    cmd.op     = OP_UPDATE;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE_OUT: begin
                if (status.out_free) begin
                    cmd.op     = OP_IDLE_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/mlfq_datapath.sv
module mlfq_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [mlfq_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [0:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mlfq_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [1:0]                          m_tuser,
    input  logic                                cfg_valid,
    input  logic [mlfq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mlfq_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  mlfq_pkg::mlfq_cmd_t                 cmd,
    output mlfq_pkg::mlfq_status_t              status
);
    import mlfq_pkg::*;

    localparam int FIFO_AW = $clog2(FIFO_DEPTH);
    localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(NUM_LEVELS - 1);

    // Configuration and time
    logic [7:0]  base_reg;
    logic [15:0] interval_reg;
    logic [31:0] clock_reg;
    logic [31:0] boost_reg;

    // Queue pointers and occupancy
    logic [SLOT_W-1:0] head_reg  [NUM_LEVELS];
    logic [CNT_W-1:0]  count_reg [NUM_LEVELS];
    logic [MAX_JOBS-1:0] queued_reg;

    // Working registers
    in_item_t          in_reg;
    logic [LVL_W-1:0]  lv_reg;
    logic [CNT_W-1:0]  k_reg;
    logic [SLOT_W-1:0] slot_reg;
    job_rec_t          rec_reg;
    logic [LVL_W-1:0]  nx_reg;
    logic [LVL_W-1:0]  pow_i_reg;
    logic [15:0]       pow_q_reg;
    logic [15:0]       t_reg;

    // Result register
    logic      m_valid_reg;
    out_item_t m_data_reg;
    logic [1:0] m_user_reg;

    // Memory ports
    logic               fifo_we;
    logic [FIFO_AW-1:0] fifo_waddr;
    logic [SLOT_W-1:0]  fifo_wdata;
    logic [FIFO_AW-1:0] fifo_raddr;
    logic [SLOT_W-1:0]  fifo_rdata;
    logic               job_we;
    logic [SLOT_W-1:0]  job_waddr;
    job_rec_t           job_wdata;
    logic [SLOT_W-1:0]  job_raddr;
    job_rec_t           job_rdata;

    // Derived values
    in_item_t          s_item;
    logic [7:0]        eff_base;
    logic [SLOT_W-1:0] in_slot;
    logic              e_reset_lvl;
    logic [LVL_W-1:0]  e_lvl;
    logic [23:0]       pow_prod;
    logic [15:0]       t_min;
    logic [31:0]       clk_new;
    logic [15:0]       work_new;
    logic [15:0]       quant_new;
    logic [15:0]       after_new;
    logic              upd_blocked;
    logic              upd_done;
    logic [1:0]        upd_outcome;
    logic [31:0]       start_new;
    logic [31:0]       ready_new;

    assign s_item   = in_item_t'(s_tdata);
    assign eff_base = (base_reg == 8'd0) ? 8'd1 : base_reg;
    assign in_slot  = in_reg.job_id[SLOT_W-1:0];

    // Level of an enqueued job and whether its level and quantum are reset
    always_comb begin
        e_reset_lvl = in_reg.is_new || (in_reg.blocked_at <= boost_reg);
        if (e_reset_lvl) begin
            e_lvl = '0;
        end else if (int'(in_reg.level) >= NUM_LEVELS) begin
            e_lvl = LAST_LVL;
        end else begin
            e_lvl = in_reg.level;
        end
    end

    assign pow_prod = pow_q_reg * eff_base;

    // Run length: the least of work, quantum and ticks to I/O.
    always_comb begin
        t_min = rec_reg.work;
        if (rec_reg.quantum < t_min) begin
            t_min = rec_reg.quantum;
        end
        if (rec_reg.has_io && rec_reg.io_after < t_min) begin
            t_min = rec_reg.io_after;
        end
    end

    // State of the job once it has run.
    always_comb begin
        clk_new     = clock_reg + {16'd0, t_reg};
        work_new    = rec_reg.work - t_reg;
        quant_new   = rec_reg.quantum - t_reg;
        after_new   = rec_reg.has_io ? rec_reg.io_after - t_reg : rec_reg.io_after;
        upd_blocked = rec_reg.has_io && (after_new == 16'd0);
        upd_done    = (work_new == 16'd0);
        start_new   = rec_reg.started ? rec_reg.start : clock_reg;
        ready_new   = upd_blocked ? clk_new + {16'd0, rec_reg.io_length} : 32'd0;
        if (upd_blocked) begin
            upd_outcome = OUT_BLOCKED;
        end else if (upd_done) begin
            upd_outcome = OUT_DONE;
        end else begin
            upd_outcome = OUT_ROTATE;
        end
    end

    // Status towards the controller
    always_comb begin
        status.in_mode    = s_tuser[0];
        status.in_queued  = queued_reg[s_item.job_id[SLOT_W-1:0]];
        status.boost_due  = (clock_reg - boost_reg) >= {16'd0, interval_reg};
        status.k_lt_count = k_reg < count_reg[lv_reg];
        status.count_nz   = count_reg[lv_reg] != '0;
        status.lv_last    = lv_reg == LAST_LVL;
        status.q_zero     = job_rdata.quantum == 16'd0;
        status.pow_done   = pow_i_reg == nx_reg;
        status.out_free   = !m_valid_reg || m_tready;
    end

    // Memory addresses and write data for each operation
    always_comb begin
        fifo_we    = 1'b0;
        fifo_waddr = '0;
        fifo_wdata = slot_reg;
        fifo_raddr = {lv_reg, head_reg[lv_reg]};
        job_we     = 1'b0;
        job_waddr  = slot_reg;
        job_wdata  = rec_reg;
        job_raddr  = fifo_rdata;
        case (cmd.op)
            OP_E_READ: begin
                job_raddr = in_slot;
            end
            OP_E_WRITE: begin
                job_we            = 1'b1;
                job_waddr         = in_slot;
                job_wdata.id      = in_reg.job_id;
                job_wdata.lvl     = e_lvl;
                job_wdata.start   = in_reg.is_new ? 32'd0 : job_rdata.start;
                job_wdata.started = in_reg.is_new ? 1'b0 : job_rdata.started;
                job_wdata.work    = in_reg.work_left;
                job_wdata.quantum = e_reset_lvl ? {8'd0, eff_base} : in_reg.quantum_left;
                job_wdata.has_io  = in_reg.has_io;
                job_wdata.io_after  = in_reg.io_after;
                job_wdata.io_length = in_reg.io_length;
                fifo_we    = 1'b1;
                fifo_waddr = {e_lvl, head_reg[e_lvl] + count_reg[e_lvl][SLOT_W-1:0]};
                fifo_wdata = in_slot;
            end
            OP_B_FREAD: begin
                fifo_raddr = {lv_reg, head_reg[lv_reg] + k_reg[SLOT_W-1:0]};
            end
            OP_B_JWRITE: begin
                job_we            = 1'b1;
                job_wdata         = job_rdata;
                job_wdata.quantum = {8'd0, eff_base};
                job_wdata.lvl     = '0;
                fifo_we    = lv_reg != '0;
                fifo_waddr = {LVL_W'(0), head_reg[0] + count_reg[0][SLOT_W-1:0]};
            end
            OP_DEMOTE: begin
                job_we            = 1'b1;
                job_wdata.quantum = pow_q_reg;
                job_wdata.lvl     = nx_reg;
                fifo_we    = 1'b1;
                fifo_waddr = {nx_reg, head_reg[nx_reg] + count_reg[nx_reg][SLOT_W-1:0]};
            end
            OP_UPDATE: begin
                job_we            = 1'b1;
                job_wdata.started = 1'b1;
                job_wdata.start   = start_new;
                job_wdata.work    = work_new;
                job_wdata.quantum = quant_new;
                job_wdata.io_after = after_new;
                job_wdata.has_io  = rec_reg.has_io && !upd_blocked;
                fifo_we    = upd_outcome == OUT_ROTATE;
                fifo_waddr = {lv_reg, head_reg[lv_reg] + count_reg[lv_reg][SLOT_W-1:0]};
            end
            default: begin
            end
        endcase
    end

    mlfq_ram #(.WIDTH(SLOT_W), .DEPTH(FIFO_DEPTH)) u_fifo_ram (
        .aclk  (aclk),
        .we    (fifo_we),
        .waddr (fifo_waddr),
        .wdata (fifo_wdata),
        .raddr (fifo_raddr),
        .rdata (fifo_rdata)
    );

    mlfq_ram #(.WIDTH($bits(job_rec_t)), .DEPTH(MAX_JOBS)) u_job_ram (
        .aclk  (aclk),
        .we    (job_we),
        .waddr (job_waddr),
        .wdata (job_wdata),
        .raddr (job_raddr),
        .rdata (job_rdata)
    );

    // Control state: configuration, time and queue pointers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg     <= 8'd4;
            interval_reg <= 16'd100;
            clock_reg    <= '0;
            boost_reg    <= '0;
            queued_reg   <= '0;
            for (int i = 0; i < NUM_LEVELS; i++) begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                if (cfg_index == CFG_BASE_QUANTUM) begin
                    base_reg <= cfg_data[7:0];
                end else if (cfg_index == CFG_BOOST_INTERVAL) begin
                    interval_reg <= cfg_data;
                end
            end
            case (cmd.op)
                OP_E_WRITE: begin
                    queued_reg[in_slot] <= 1'b1;
                    count_reg[e_lvl]    <= count_reg[e_lvl] + 1'b1;
                end
                OP_BOOST: begin
                    boost_reg <= clock_reg;
                end
                OP_B_NEXTLVL: begin
                    if (lv_reg != '0) begin
                        head_reg[lv_reg]  <= head_reg[lv_reg]
                                             + count_reg[lv_reg][SLOT_W-1:0];
                        count_reg[lv_reg] <= '0;
                    end
                end
                OP_B_JWRITE: begin
                    if (lv_reg != '0) begin
                        count_reg[0] <= count_reg[0] + 1'b1;
                    end
                end
                OP_DEMOTE: begin
                    head_reg[lv_reg] <= head_reg[lv_reg] + 1'b1;
                    if (nx_reg != lv_reg) begin
                        count_reg[lv_reg] <= count_reg[lv_reg] - 1'b1;
                        count_reg[nx_reg] <= count_reg[nx_reg] + 1'b1;
                    end
                end
                OP_UPDATE: begin
                    clock_reg        <= clk_new;
                    head_reg[lv_reg] <= head_reg[lv_reg] + 1'b1;
                    if (upd_outcome != OUT_ROTATE) begin
                        count_reg[lv_reg]    <= count_reg[lv_reg] - 1'b1;
                        queued_reg[slot_reg] <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Result valid: set when a report is written, cleared when it is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.op == OP_UPDATE || cmd.op == OP_IDLE_OUT) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Working and result payload registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_ACCEPT: begin
                in_reg <= s_item;
            end
            OP_BOOST, OP_S_START: begin
                lv_reg <= '0;
                k_reg  <= '0;
            end
            OP_B_NEXTLVL: begin
                lv_reg <= (lv_reg == LAST_LVL) ? '0 : lv_reg + 1'b1;
                k_reg  <= '0;
            end
            OP_B_JREAD, OP_S_JREAD: begin
                slot_reg <= fifo_rdata;
            end
            OP_B_JWRITE: begin
                k_reg <= k_reg + 1'b1;
            end
            OP_S_NEXTLVL: begin
                lv_reg <= lv_reg + 1'b1;
            end
            OP_S_EVAL: begin
                rec_reg   <= job_rdata;
                nx_reg    <= (lv_reg == LAST_LVL) ? lv_reg : lv_reg + 1'b1;
                pow_q_reg <= 16'd1;
                pow_i_reg <= '0;
            end
            OP_POW: begin
                pow_q_reg <= (pow_prod > 24'h00FFFF) ? 16'hFFFF : pow_prod[15:0];
                pow_i_reg <= pow_i_reg + 1'b1;
            end
            OP_RUN: begin
                t_reg <= t_min;
            end
            OP_UPDATE: begin
                m_user_reg             <= upd_outcome;
                m_data_reg.pad         <= '0;
                m_data_reg.job_id_res  <= rec_reg.id;
                m_data_reg.ran_ticks   <= t_reg;
                m_data_reg.now_time    <= clk_new;
                m_data_reg.first_run   <= start_new;
                m_data_reg.ready_at    <= ready_new;
                m_data_reg.out_level   <= rec_reg.lvl;
                m_data_reg.out_quantum <= quant_new;
                m_data_reg.out_work    <= work_new;
            end
            OP_IDLE_OUT: begin
                m_user_reg          <= OUT_IDLE;
                m_data_reg          <= '0;
                m_data_reg.now_time <= clock_reg;
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

>>> rtl/mlfq_scheduler_core.sv
// Multilevel feedback queue scheduler.
// Input channel s_*: one transaction is an enqueue (s_tuser = 0) or a dispatch
// request (s_tuser = 1). An enqueue gives no result; a dispatch always gives
// exactly one result transaction on m_*, either the job that ran or an idle
// report. Configuration writes on cfg_* are always accepted; the user is to send
// them only while the block is idle, which the block itself does not enforce.
// Timing: an enqueue reads and then writes the job memory, unless its slot already
// holds a queued job. A dispatch that runs a job passes each empty level in turn, and
// an idle report passes all levels. Each demoted front job adds the build of its new
// quantum, as the quantum power is built one multiply a cycle, and a due priority
// boost walks every queued job and every level. The cost is set by the single read
// port of the job memory and of the queue memory, which the controller walks one
// access at a time. Items are handled one at a time; s_tready is high only while the
// controller is waiting for work.
// Reset empties all queues, clears time and restores the default registers.
// When the receiver stalls, the result waits in the output register; a new
// transaction may still be accepted, and a following dispatch holds before
// writing its result until the register is free.
module mlfq_scheduler_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // job_id[7:0], is_new[8], level[11:9], quantum_left[27:12], work_left[43:28],
    // has_io[44], io_after[60:45], io_length[76:61], blocked_at[108:77]
    input  logic [mlfq_pkg::S_TDATA_W-1:0]      s_tdata,
    // mode[0]
    input  logic [0:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // job_id_res[7:0], ran_ticks[23:8], now_time[55:24], first_run[87:56],
    // ready_at[119:88], out_level[122:120], out_quantum[138:123], out_work[154:139]
    output logic [mlfq_pkg::M_TDATA_W-1:0]      m_tdata,
    // outcome[1:0]
    output logic [1:0]                          m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mlfq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mlfq_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import mlfq_pkg::*;

    mlfq_cmd_t    cmd;
    mlfq_status_t status;

    assign cfg_ready = 1'b1;

    mlfq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mlfq_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

>>> rtl/mlfq_checker.sv
module mlfq_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [mlfq_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [1:0]                     m_tuser
);
    import mlfq_pkg::*;

    // Reset leaves no result pending.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // An idle report names no job and no run.
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == OUT_IDLE |-> m_tdata[23:0] == 24'd0)
        else $error("idle result carries a job");

    // The I/O end time is given only for a blocked job.
    a_ready_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != OUT_BLOCKED |-> m_tdata[119:88] == 32'd0)
        else $error("ready time on a result that is not blocked");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind mlfq_scheduler_core mlfq_checker u_mlfq_checker (.*);

>>> sim/mlfq_scheduler_core_tb.sv
module mlfq_scheduler_core_tb;
    import mlfq_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD   = 300;

    // One transaction on the input channel and one expected dispatch report
    typedef struct {
        logic     mode;
        in_item_t d;
    } sched_req_t;

    typedef struct {
        logic [1:0] outcome;
        out_item_t  d;
    } sched_res_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [0:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [1:0]            m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    mlfq_scheduler_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow scheduler state
    logic [5:0]  lq_slot [NUM_LEVELS][MAX_JOBS];
    int unsigned lq_head [NUM_LEVELS];
    int unsigned lq_cnt  [NUM_LEVELS];
    logic [15:0] job_work    [MAX_JOBS];
    logic [15:0] job_slice   [MAX_JOBS];
    logic        job_has_io  [MAX_JOBS];
    logic [15:0] job_io_wait [MAX_JOBS];
    logic [15:0] job_io_len  [MAX_JOBS];
    logic [7:0]  job_ident   [MAX_JOBS];
    logic [2:0]  job_level   [MAX_JOBS];
    logic [31:0] job_first   [MAX_JOBS];
    logic        job_started [MAX_JOBS];
    logic        job_queued  [MAX_JOBS];
    logic        slot_seeded [MAX_JOBS];
    logic [31:0] sched_clock;
    logic [31:0] boost_mark;
    logic [7:0]  base_slice;
    logic [15:0] boost_period;

    sched_req_t sched_pending[$];
    sched_res_t dispatch_expected[$];
    sched_req_t drive_item;
    sched_res_t predicted;
    int         errors = 0;
    int         gap_left = 0;
    bit         calm = 1'b0;
    bit         long_hold_req = 1'b0;
    int         quiet_cycles = 0;

    function automatic logic [15:0] eff_base();
        return (base_slice == 8'd0) ? 16'd1 : {8'd0, base_slice};
    endfunction

    // Slice for a level: base to the power of the level, saturated.
    function automatic logic [15:0] level_slice(int lv);
        int unsigned q;
        q = 1;
        for (int i = 0; i < lv; i++) begin
            q = q * eff_base();
            if (q > 65535) return 16'hFFFF;
        end
        return q[15:0];
    endfunction

    function automatic void lq_push(int lv, logic [5:0] slot);
        if (lq_cnt[lv] >= MAX_JOBS) return;
        lq_slot[lv][(lq_head[lv] + lq_cnt[lv]) % MAX_JOBS] = slot;
        lq_cnt[lv]++;
    endfunction

    function automatic logic [5:0] lq_pop(int lv);
        logic [5:0] slot;
        slot = lq_slot[lv][lq_head[lv]];
        lq_head[lv] = (lq_head[lv] + 1) % MAX_JOBS;
        lq_cnt[lv]--;
        return slot;
    endfunction

    // Appends one transaction to the driver's queue.
    function automatic void queue_item(sched_req_t it);
        sched_pending = {sched_pending, it};
    endfunction

    // Priority boost: every queued job goes to level 0 in level order.
    function automatic void boost_all();
        logic [5:0] held [MAX_JOBS];
        int n;
        n = 0;
        for (int lv = 0; lv < NUM_LEVELS; lv++) begin
            while (lq_cnt[lv] > 0 && n < MAX_JOBS) begin
                held[n] = lq_pop(lv);
                n++;
            end
        end
        for (int i = 0; i < n; i++) begin
            job_slice[held[i]] = eff_base();
            job_level[held[i]] = 3'd0;
            lq_push(0, held[i]);
        end
        boost_mark = sched_clock;
    endfunction

    // Applies one accepted transaction; returns 1 when a dispatch report follows.
    function automatic bit schedule_step(input sched_req_t q, output sched_res_t r);
        logic [5:0]  s;
        logic [15:0] t;
        logic [1:0]  outcome;
        logic [31:0] ready;
        int          nx;
        r.outcome = OUT_IDLE;
        r.d = '0;
        ready = '0;
        if (!q.mode) begin
            s = q.d.job_id[5:0];
            if (job_queued[s]) return 1'b0;
            job_ident[s]   = q.d.job_id;
            job_work[s]    = q.d.work_left;
            job_has_io[s]  = q.d.has_io;
            job_io_wait[s] = q.d.io_after;
            job_io_len[s]  = q.d.io_length;
            job_level[s]   = q.d.level;
            if (q.d.is_new) begin
                job_started[s] = 1'b0;
                job_first[s]   = '0;
                job_level[s]   = 3'd0;
                job_slice[s]   = eff_base();
                slot_seeded[s] = 1'b1;
            end else if (q.d.blocked_at <= boost_mark) begin
                job_level[s] = 3'd0;
                job_slice[s] = eff_base();
            end else begin
                job_slice[s] = q.d.quantum_left;
            end
            job_queued[s] = 1'b1;
            lq_push(job_level[s], s);
            return 1'b0;
        end

        if (32'(sched_clock - boost_mark) >= {16'd0, boost_period}) boost_all();

        // Scan from the highest priority; exhausted front jobs are demoted.
        for (int lv = 0; lv < NUM_LEVELS; lv++) begin
            while (lq_cnt[lv] > 0) begin
                s = lq_slot[lv][lq_head[lv]];
                if (job_slice[s] == 16'd0) begin
                    nx = (lv + 1 < NUM_LEVELS) ? lv + 1 : NUM_LEVELS - 1;
                    void'(lq_pop(lv));
                    job_slice[s] = level_slice(nx);
                    job_level[s] = nx[2:0];
                    lq_push(nx, s);
                    continue;
                end
                if (!job_started[s]) begin
                    job_started[s] = 1'b1;
                    job_first[s]   = sched_clock;
                end
                t = job_work[s];
                if (job_slice[s] < t) t = job_slice[s];
                if (job_has_io[s] && job_io_wait[s] < t) t = job_io_wait[s];
                sched_clock  = sched_clock + t;
                job_work[s]  = job_work[s] - t;
                job_slice[s] = job_slice[s] - t;
                if (job_has_io[s]) job_io_wait[s] = job_io_wait[s] - t;
                void'(lq_pop(lv));
                if (job_has_io[s] && job_io_wait[s] == 16'd0) begin
                    ready = sched_clock + job_io_len[s];
                    job_has_io[s] = 1'b0;
                    job_queued[s] = 1'b0;
                    outcome = OUT_BLOCKED;
                end else if (job_work[s] == 16'd0) begin
                    job_queued[s] = 1'b0;
                    outcome = OUT_DONE;
                end else begin
                    lq_push(lv, s);
                    outcome = OUT_ROTATE;
                end
                r.outcome       = outcome;
                r.d.job_id_res  = job_ident[s];
                r.d.ran_ticks   = t;
                r.d.now_time    = sched_clock;
                r.d.first_run   = job_first[s];
                r.d.ready_at    = ready;
                r.d.out_level   = job_level[s];
                r.d.out_quantum = job_slice[s];
                r.d.out_work    = job_work[s];
                return 1'b1;
            end
        end
        r.d.now_time = sched_clock;
        return 1'b1;
    endfunction

    function automatic sched_req_t mk_item(logic mode, logic [7:0] id, logic is_new,
                                           logic [2:0] lvl, logic [15:0] q,
                                           logic [15:0] work, logic has_io,
                                           logic [15:0] after, logic [15:0] len,
                                           logic [31:0] blk);
        sched_req_t it;
        it.mode = mode;
        it.d = '0;
        it.d.job_id = id;
        it.d.is_new = is_new;
        it.d.level = lvl;
        it.d.quantum_left = q;
        it.d.work_left = work;
        it.d.has_io = has_io;
        it.d.io_after = after;
        it.d.io_length = len;
        it.d.blocked_at = blk;
        return it;
    endfunction

    // Random transaction; returning jobs only use slots that have held a new job.
    function automatic sched_req_t rand_item();
        sched_req_t it;
        logic [7:0]  id;
        logic [15:0] work, q, after;
        logic [31:0] blk;
        id = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0:       work = 16'd0;
            1:       work = 16'($urandom_range(0, 65535));
            default: work = 16'($urandom_range(1, 12));
        endcase
        case ($urandom_range(0, 5))
            0, 1:    q = 16'd0;
            2:       q = 16'($urandom_range(0, 65535));
            default: q = 16'($urandom_range(1, 20));
        endcase
        case ($urandom_range(0, 7))
            0:       after = 16'd0;
            1:       after = 16'($urandom_range(0, 65535));
            default: after = 16'($urandom_range(1, 15));
        endcase
        case ($urandom_range(0, 4))
            0:       blk = 32'd0;
            1:       blk = 32'hFFFF_FFFF;
            2:       blk = $urandom;
            default: blk = boost_mark + $urandom_range(0, 6) - 32'd3;
        endcase
        it = mk_item(1'($urandom_range(0, 1)), id,
                     slot_seeded[id[5:0]] ? 1'($urandom_range(0, 1)) : 1'b1,
                     3'($urandom_range(0, 7)), q, work, 1'($urandom_range(0, 1)),
                     after, 16'($urandom_range(0, 65535)), blk);
        return it;
    endfunction

    // Clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Input driver: predicts each accepted transaction and offers the next one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                if (schedule_step(drive_item, predicted))
                    dispatch_expected = {dispatch_expected, predicted};
            end
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(0, 11) == 0) begin
                gap_left = $urandom_range(0, 8);
                s_tvalid <= 1'b0;
            end else if (sched_pending.size() > 0) begin
                drive_item = sched_pending.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= S_TDATA_W'(drive_item.d);
                s_tuser  <= drive_item.mode;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    task automatic check_field(string nm, logic [31:0] e, logic [31:0] a);
        if (e !== a) begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, nm, e, a);
        end
    endtask

    // Result monitor with random and long receiver stalls.
    int hold_left = 0;
    always @(posedge aclk) begin
        sched_res_t exp_res;
        out_item_t  act;
        if (m_tvalid && m_tready) begin
            act = out_item_t'(m_tdata[$bits(out_item_t)-1:0]);
            if (dispatch_expected.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none actual %h/%h",
                         $time, m_tuser, m_tdata);
            end else begin
                exp_res = dispatch_expected.pop_front();
                check_field("job_id_res", exp_res.d.job_id_res, act.job_id_res);
                check_field("outcome", exp_res.outcome, m_tuser);
                check_field("ran_ticks", exp_res.d.ran_ticks, act.ran_ticks);
                check_field("now_time", exp_res.d.now_time, act.now_time);
                check_field("first_run", exp_res.d.first_run, act.first_run);
                check_field("ready_at", exp_res.d.ready_at, act.ready_at);
                check_field("out_level", exp_res.d.out_level, act.out_level);
                check_field("out_quantum", exp_res.d.out_quantum, act.out_quantum);
                check_field("out_work", exp_res.d.out_work, act.out_work);
            end
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            hold_left = $urandom_range(0, 8);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_BASE_QUANTUM) base_slice = val[7:0];
        else if (idx == CFG_BOOST_INTERVAL) boost_period = val;
    endtask

    // Waits until every transaction is sent and every report has come back.
    task automatic wait_drained();
        do @(posedge aclk);
        while (sched_pending.size() > 0 || s_tvalid || dispatch_expected.size() > 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic random_phase(int n, bit with_long_hold);
        for (int i = 0; i < n; i++) queue_item(rand_item());
        if (with_long_hold) long_hold_req = 1'b1;
        wait_drained();
    endtask

    // Stimulus sequence
    initial begin
        base_slice   = 8'd4;
        boost_period = 16'd100;
        sched_clock  = '0;
        boost_mark   = '0;
        for (int lv = 0; lv < NUM_LEVELS; lv++) begin
            lq_head[lv] = 0;
            lq_cnt[lv]  = 0;
        end
        for (int s = 0; s < MAX_JOBS; s++) begin
            job_queued[s]  = 1'b0;
            slot_seeded[s] = 1'b0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty dispatch, zero work, blocking, occupied slot, rotation.
        queue_item(mk_item(1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_item(mk_item(0, 0, 1, 0, 0, 0, 0, 0, 0, 0));
        queue_item(mk_item(1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_item(mk_item(0, 255, 1, 7, 16'hFFFF, 16'hFFFF, 1, 1, 16'hFFFF,
                           32'hFFFF_FFFF));
        queue_item(mk_item(0, 5, 1, 0, 0, 10, 0, 0, 0, 0));
        queue_item(mk_item(0, 69, 1, 0, 0, 3, 0, 0, 0, 0));
        queue_item(mk_item(0, 130, 1, 0, 0, 3, 1, 0, 7, 0));
        for (int i = 0; i < 6; i++)
            queue_item(mk_item(1, 8'hFF, 1, 7, 16'hFFFF, 16'hFFFF, 1,
                               16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
        wait_drained();

        // Directed: returning jobs, demotion at the last level, boost window.
        queue_item(mk_item(0, 0, 0, 7, 0, 100, 0, 0, 0, 32'hFFFF_FFFF));
        queue_item(mk_item(0, 255, 0, 3, 9, 20, 0, 0, 0, 0));
        queue_item(mk_item(0, 130, 0, 6, 16'hFFFF, 16'hFFFF, 0, 0, 0,
                           32'hFFFF_FFFF));
        queue_item(mk_item(0, 64, 0, 2, 0, 5, 1, 2, 0, 32'hFFFF_FFFF));
        for (int i = 0; i < 8; i++)
            queue_item(mk_item(1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        wait_drained();

        // Random phases over several register settings.
        random_phase(160, 1'b1);
        write_reg(CFG_BASE_QUANTUM, 16'd0);
        write_reg(CFG_BOOST_INTERVAL, 16'd0);
        random_phase(150, 1'b0);
        write_reg(CFG_BASE_QUANTUM, 16'd255);
        write_reg(CFG_BOOST_INTERVAL, 16'hFFFF);
        random_phase(160, 1'b0);
        write_reg(CFG_BASE_QUANTUM, 16'd1);
        write_reg(CFG_BOOST_INTERVAL, 16'd1);
        random_phase(150, 1'b0);
        write_reg(CFG_BASE_QUANTUM, 16'd2);
        write_reg(CFG_BOOST_INTERVAL, 16'd50);
        random_phase(150, 1'b1);
        write_reg(CFG_BASE_QUANTUM, 16'($urandom_range(0, 255)));
        write_reg(CFG_BOOST_INTERVAL, 16'($urandom_range(0, 65535)));
        calm = 1'b1;
        random_phase(150, 1'b0);

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
